// ===== rtl/core/mbrtu_pkg.sv =====
// shared types and constants for the rtu slave frame engine
package mbrtu_pkg;

   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  FC_READ_HOLDING = 8'd3;
   localparam logic [7:0]  FC_WRITE_SINGLE = 8'd6;
   localparam logic [7:0]  EXC_ILLEGAL_FUNCTION = 8'd1;
   localparam logic [7:0]  EXC_ILLEGAL_ADDRESS = 8'd2;
   localparam logic [7:0]  EXC_FLAG = 8'h80;
   localparam logic        CSR_OWN_ADDRESS = 1'b0;
   localparam logic        CSR_MAX_REPLY_LEN = 1'b1;

   // reply byte source selected by the controller
   typedef enum logic [2:0] {
      SRC_ADDR,
      SRC_FC,
      SRC_EXC,
      SRC_BCOUNT,
      SRC_HDR,
      SRC_REG,
      SRC_CRC_LO,
      SRC_CRC_HI
   } src_type;

   typedef struct packed {
      logic       rx_take;     // intake byte
      logic       clear;       // frame clear
      logic       crc_err_inc;
      logic       served_inc;
      logic       reg_write;
      logic       tx_crc_init;
      logic       tx_load;     // load output register and feed tx crc with non-crc bytes
      src_type    src;
      logic [7:0] exc_code;
      logic [2:0] hdr_idx;
      logic       reg_hi;
      logic       tx_last;
   } cmd_type;

   typedef struct packed {
      logic       short_frame;
      logic       crc_ok;
      logic       addr_ok;
      logic [7:0] fc;
      logic       read_bad;
      logic       write_bad;
      logic [7:0] count;
   } sts_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/mbrtu_stream_if.sv =====
// valid/ready channel carrying a packed payload
interface mbrtu_stream_if #(parameter int WIDTH = 9);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mbrtu_ram.sv =====
// generic simple dual port ram (one write port, one read port) with registered read
module mbrtu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/core/mbrtu_datapath.sv =====
// frame intake, crc, header, counters, register file and reply byte path
module mbrtu_datapath #(
   parameter int NUM_HOLDING_REGS = 32,
   parameter int MAX_REPLY_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mbrtu_pkg::cmd_type    cmd,
   output mbrtu_pkg::sts_type    sts,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            own_address,
   input  logic [6:0]            max_reply_len,
   input  logic [6:0]            reg_idx,
   output logic [7:0]            tx_byte,
   output logic                  tx_last,
   output logic [15:0]           crc_err_cnt,
   output logic [15:0]           served_cnt,
   output logic                  clear_busy
);
   import mbrtu_pkg::*;
   localparam int AW = (NUM_HOLDING_REGS > 1) ? $clog2(NUM_HOLDING_REGS) : 1;

   logic [15:0] crc_ff, crc_in, txcrc_ff, txcrc_in;
   logic [7:0]  dly_ff [2];
   logic [7:0]  hdr_ff [6];
   logic [7:0]  pos_ff;
   logic [15:0] crc_err_ff, served_ff;
   logic [7:0]  tx_byte_ff, tx_byte_in;
   logic        tx_last_ff;
   logic [7:0]  reg_lo_ff;   // low byte of the word whose high byte just went out
   logic [AW:0] clr_ff;
   logic [15:0] rd_data;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [15:0] start, count, waddr;
   logic [16:0] end_sum;
   logic [17:0] need;
   logic [6:0]  limit;

   assign start = {hdr_ff[2], hdr_ff[3]};
   assign count = {hdr_ff[4], hdr_ff[5]};
   assign waddr = start;
   assign end_sum = {1'b0, start} + {1'b0, count};
   assign need = {1'b0, count, 1'b0} + 18'd5;
   assign limit = (max_reply_len > 7'(MAX_REPLY_BYTES)) ? 7'(MAX_REPLY_BYTES) : max_reply_len;

   always_comb begin
      sts.short_frame = pos_ff < 8'd4;
      sts.crc_ok = {rx_byte, dly_ff[1]} == crc_in;
      sts.addr_ok = (hdr_ff[0] == own_address) || (hdr_ff[0] == 8'd0);
      sts.fc = hdr_ff[1];
      sts.read_bad = (end_sum > 17'(NUM_HOLDING_REGS)) || (need > {11'd0, limit});
      sts.write_bad = {16'd0, waddr} >= 32'(NUM_HOLDING_REGS);
      sts.count = count[7:0];
   end

   // the crc for the current frame end byte: feed the older delayed byte
   assign crc_in = (pos_ff >= 8'd2) ? crc_feed(crc_ff, dly_ff[0]) : crc_ff;

   assign rd_addr = AW'(start + {9'd0, reg_idx});
   assign wr_addr = clear_busy ? clr_ff[AW-1:0] : waddr[AW-1:0];
   assign clear_busy = (clr_ff != (AW+1)'(NUM_HOLDING_REGS));

   mbrtu_ram #(.WIDTH(16), .DEPTH(NUM_HOLDING_REGS)) u_regs (
      .clock   (clock),
      .wr_en   (cmd.reg_write || clear_busy),
      .wr_addr (wr_addr),
      .wr_data (clear_busy ? 16'd0 : count),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      case (cmd.src)
         SRC_ADDR:   tx_byte_in = own_address;
         SRC_FC:     tx_byte_in = hdr_ff[1] | ((cmd.exc_code != 8'd0) ? EXC_FLAG : 8'd0);
         SRC_EXC:    tx_byte_in = cmd.exc_code;
         SRC_BCOUNT: tx_byte_in = {count[6:0], 1'b0};
         SRC_HDR:    tx_byte_in = hdr_ff[(cmd.hdr_idx > 3'd5) ? 3'd5 : cmd.hdr_idx];
         SRC_REG:    tx_byte_in = cmd.reg_hi ? rd_data[15:8] : reg_lo_ff;
         SRC_CRC_LO: tx_byte_in = txcrc_ff[7:0];
         SRC_CRC_HI: tx_byte_in = txcrc_ff[15:8];
         default:    tx_byte_in = 8'd0;
      endcase
   end
   assign txcrc_in = cmd.tx_crc_init ? CRC_SEED : crc_feed(txcrc_ff, tx_byte_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_SEED;
         dly_ff <= '{default: 8'd0};
         hdr_ff <= '{default: 8'd0};
         pos_ff <= 8'd0;
         crc_err_ff <= 16'd0;
         served_ff <= 16'd0;
         clr_ff <= '0;
         txcrc_ff <= CRC_SEED;
      end else begin
         if (clear_busy) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.clear) begin
            crc_ff <= CRC_SEED;
            dly_ff <= '{default: 8'd0};
            hdr_ff <= '{default: 8'd0};
            pos_ff <= 8'd0;
         end else if (cmd.rx_take) begin
            if (pos_ff < 8'd6) begin
               hdr_ff[pos_ff[2:0]] <= rx_byte;
            end
            crc_ff <= crc_in;
            dly_ff[0] <= dly_ff[1];
            dly_ff[1] <= rx_byte;
            if (pos_ff != 8'd255) begin
               pos_ff <= pos_ff + 8'd1;
            end
         end
         if (cmd.crc_err_inc) begin
            crc_err_ff <= crc_err_ff + 16'd1;
         end
         if (cmd.served_inc) begin
            served_ff <= served_ff + 16'd1;
         end
         // the crc bytes themselves are not fed
         if (cmd.tx_crc_init ||
             (cmd.tx_load && cmd.src != SRC_CRC_LO && cmd.src != SRC_CRC_HI)) begin
            txcrc_ff <= txcrc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tx_load) begin
         tx_byte_ff <= tx_byte_in;
         tx_last_ff <= cmd.tx_last;
      end
      if (cmd.tx_load && cmd.src == SRC_REG && cmd.reg_hi) begin
         reg_lo_ff <= rd_data[7:0];
      end
   end

   assign tx_byte = tx_byte_ff;
   assign tx_last = tx_last_ff;
   assign crc_err_cnt = crc_err_ff;
   assign served_cnt = served_ff;
endmodule

// ===== rtl/core/mbrtu_ctrl.sv =====
// controller: frame end decision and reply sequencing
module mbrtu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_end,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               clear_busy,
   input  mbrtu_pkg::sts_type sts,
   output mbrtu_pkg::cmd_type cmd,
   output logic [6:0]         reg_idx
);
   import mbrtu_pkg::*;

   typedef enum logic [2:0] {
      ST_RX, ST_DECIDE, ST_HEAD, ST_BODY, ST_CRC, ST_WAIT
   } state_type;

   typedef enum logic [1:0] {K_EXC, K_READ, K_ECHO} kind_type;

   state_type  state_ff;
   kind_type   kind_ff;
   logic [7:0] exc_ff;
   logic [7:0] step_ff;   // byte index within the reply body
   logic [7:0] nbody_ff;  // bytes before the crc
   logic       rsp_valid_ff;
   logic       slot_free;
   logic       crc_ok_ff;
   logic [6:0] reg_idx_ff;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_RX) && !clear_busy;
   assign reg_idx = reg_idx_ff;

   always_comb begin
      cmd = '0;
      cmd.src = SRC_ADDR;
      cmd.rx_take = req_valid && req_ready;
      case (state_ff)
         ST_HEAD, ST_BODY: begin
            cmd.tx_load = slot_free;
            cmd.exc_code = (kind_ff == K_EXC) ? exc_ff : 8'd0;
            if (kind_ff == K_ECHO) begin
               cmd.src = SRC_HDR;
               cmd.hdr_idx = step_ff[2:0];
            end else if (step_ff == 8'd0) begin
               cmd.src = SRC_ADDR;
            end else if (step_ff == 8'd1) begin
               cmd.src = SRC_FC;
            end else if (step_ff == 8'd2) begin
               cmd.src = (kind_ff == K_EXC) ? SRC_EXC : SRC_BCOUNT;
            end else begin
               // odd steps carry the high byte of a register
               cmd.src = SRC_REG;
               cmd.reg_hi = step_ff[0];
            end
         end
         ST_CRC: begin
            cmd.tx_load = slot_free;
            cmd.src = step_ff[0] ? SRC_CRC_HI : SRC_CRC_LO;
            cmd.tx_last = step_ff[0];
         end
         ST_DECIDE: begin
            cmd.tx_crc_init = 1'b1;
            // a dropped frame is cleared now, an answered one after its reply
            cmd.clear = sts.short_frame || !crc_ok_ff || !sts.addr_ok;
            if (sts.short_frame) begin
            end else if (!crc_ok_ff) begin
               cmd.crc_err_inc = 1'b1;
            end else if (sts.addr_ok) begin
               cmd.served_inc = 1'b1;
               cmd.reg_write = (sts.fc == FC_WRITE_SINGLE) && !sts.write_bad;
            end
         end
         ST_WAIT: begin
            cmd.clear = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RX;
         rsp_valid_ff <= 1'b0;
         kind_ff <= K_EXC;
         exc_ff <= 8'd0;
         step_ff <= 8'd0;
         nbody_ff <= 8'd0;
         crc_ok_ff <= 1'b0;
         reg_idx_ff <= 7'd0;
      end else begin
         rsp_valid_ff <= cmd.tx_load || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            ST_RX: begin
               if (cmd.rx_take && req_end) begin
                  crc_ok_ff <= sts.crc_ok;
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               step_ff <= 8'd0;
               reg_idx_ff <= 7'd0;
               if (sts.short_frame || !crc_ok_ff || !sts.addr_ok) begin
                  state_ff <= ST_RX;
               end else begin
                  state_ff <= ST_HEAD;
                  if (sts.fc == FC_READ_HOLDING && !sts.read_bad) begin
                     kind_ff <= K_READ;
                     exc_ff <= 8'd0;
                     nbody_ff <= 8'd3 + {sts.count[6:0], 1'b0};
                  end else if (sts.fc == FC_WRITE_SINGLE && !sts.write_bad) begin
                     kind_ff <= K_ECHO;
                     exc_ff <= 8'd0;
                     nbody_ff <= 8'd6;
                  end else begin
                     kind_ff <= K_EXC;
                     nbody_ff <= 8'd3;
                     exc_ff <= (sts.fc == FC_READ_HOLDING || sts.fc == FC_WRITE_SINGLE)
                        ? EXC_ILLEGAL_ADDRESS : EXC_ILLEGAL_FUNCTION;
                  end
               end
            end
            ST_HEAD, ST_BODY: begin
               if (slot_free) begin
                  if (step_ff >= 8'd3 && step_ff[0]) begin
                     reg_idx_ff <= reg_idx_ff + 7'd1;
                  end
                  if (step_ff + 8'd1 == nbody_ff) begin
                     state_ff <= ST_CRC;
                     step_ff <= 8'd0;
                  end else begin
                     state_ff <= ST_BODY;
                     step_ff <= step_ff + 8'd1;
                  end
               end
            end
            ST_CRC: begin
               if (slot_free) begin
                  step_ff <= step_ff + 8'd1;
                  if (step_ff[0]) begin
                     state_ff <= ST_WAIT;
                  end
               end
            end
            ST_WAIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= ST_RX;
               end
            end
            default: state_ff <= ST_RX;
         endcase
      end
   end
endmodule

// ===== rtl/core/modbus_rtu_slave_frame_engine_unit.sv =====
// top level of the rtu slave frame engine
//  channel | dir | payload                                          | handshake
//  req     | in  | rx_byte[7:0], frame_end                          | valid/ready
//  rsp     | out | tx_byte, reply_last, crc_error_total, served_tot | valid/ready
//  csr     | in  | index, 8-bit data                                | write enable
// one byte per cycle on intake while req_ready is high; a dropped frame still passes the decide state
// a reply keeps intake closed through the decide state, the output loads of its bytes, crc included,
// and the wait for its last transaction to be taken
// reset runs a clearing pass that writes zero to every entry of the register file
// register read data comes from the ram in the cycle after the address steps
// rsp stalls hold the reply sequencer; req_ready drops while a reply is out
module modbus_rtu_slave_frame_engine_unit #(
   parameter int NUM_HOLDING_REGS = 32,
   parameter int MAX_REPLY_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   mbrtu_stream_if.sink   req,
   mbrtu_stream_if.source rsp,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);
   import mbrtu_pkg::*;

   logic [7:0]  own_address_ff;
   logic [6:0]  max_reply_len_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic [6:0]  reg_idx;
   logic [7:0]  tx_byte;
   logic        tx_last;
   logic [15:0] crc_err_cnt, served_cnt;
   logic        clear_busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= 8'd1;
         max_reply_len_ff <= 7'd64;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_OWN_ADDRESS:   own_address_ff <= csr_write_data;
            CSR_MAX_REPLY_LEN: max_reply_len_ff <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   mbrtu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_end    (req.data[8]),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .clear_busy (clear_busy),
      .sts        (sts),
      .cmd        (cmd),
      .reg_idx    (reg_idx)
   );

   mbrtu_datapath #(
      .NUM_HOLDING_REGS (NUM_HOLDING_REGS),
      .MAX_REPLY_BYTES  (MAX_REPLY_BYTES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .rx_byte       (req.data[7:0]),
      .own_address   (own_address_ff),
      .max_reply_len (max_reply_len_ff),
      .reg_idx       (reg_idx),
      .tx_byte       (tx_byte),
      .tx_last       (tx_last),
      .crc_err_cnt   (crc_err_cnt),
      .served_cnt    (served_cnt),
      .clear_busy    (clear_busy)
   );

   // payload: {served_total, crc_error_total, reply_last, tx_byte}
   assign rsp.data = {served_cnt, crc_err_cnt, tx_last, tx_byte};
endmodule

// ===== dv/modbus_rtu_slave_frame_engine_unit_tb.sv =====
// self-checking testbench for the rtu slave frame engine
module modbus_rtu_slave_frame_engine_unit_tb;
   import mbrtu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_REGS = 32;
   localparam int REPLY_CAP = 64;

   // one reply byte as it leaves the block
   typedef struct packed {
      logic [15:0] served_total;
      logic [15:0] crc_error_total;
      logic        reply_last;
      logic [7:0]  tx_byte;
   } reply_beat_t;

   logic       clock;
   logic       reset;
   logic       csr_write_en;
   logic       csr_index;
   logic [7:0] csr_write_data;

   mbrtu_stream_if #(.WIDTH(9))  req_if ();
   mbrtu_stream_if #(.WIDTH(41)) rsp_if ();

   modbus_rtu_slave_frame_engine_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // free-running clock, 8 ns period
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ---------------------------------------------------------------
   // shadow of the slave: configuration, frame intake and registers
   // ---------------------------------------------------------------
   logic [7:0]  node_addr;
   logic [6:0]  reply_len_limit;
   logic [15:0] frame_crc;
   logic [7:0]  crc_tail [2];
   logic [7:0]  frame_hdr [6];
   logic [7:0]  frame_pos;
   logic [15:0] holding_regs [NUM_REGS];
   logic [15:0] crc_err_count;
   logic [15:0] served_count;

   reply_beat_t pending_replies [$];   // reply bytes still to come out
   int          mismatches;
   bit          calm;                  // when set, neither side idles

   // reflected crc-16, one byte
   function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function automatic void restart_frame();
      frame_crc = 16'hFFFF;
      crc_tail[0] = 8'h00;
      crc_tail[1] = 8'h00;
      for (int i = 0; i < 6; i++) frame_hdr[i] = 8'h00;
      frame_pos = 8'd0;
   endfunction

   // advance the shadow by one received byte, queue any reply it causes
   function automatic void absorb_rx_byte(logic [7:0] b, logic last);
      logic [7:0]  pos;
      logic [7:0]  fc;
      logic [7:0]  reply [$];
      logic [16:0] first_reg;
      logic [16:0] word_count;
      int          cap;
      logic [15:0] crc;
      reply_beat_t beat;
      pos = frame_pos;
      if (pos < 6) frame_hdr[pos] = b;
      if (pos >= 2) frame_crc = crc16_byte(frame_crc, crc_tail[0]);
      crc_tail[0] = crc_tail[1];
      crc_tail[1] = b;
      if (pos < 255) frame_pos = pos + 8'd1;
      if (!last) return;
      // runt frame: dropped without any count
      if (pos < 3) begin
         restart_frame();
         return;
      end
      if ({crc_tail[1], crc_tail[0]} != frame_crc) begin
         crc_err_count = crc_err_count + 16'd1;
         restart_frame();
         return;
      end
      // not ours and not broadcast
      if (frame_hdr[0] != node_addr && frame_hdr[0] != 8'h00) begin
         restart_frame();
         return;
      end
      fc = frame_hdr[1];
      cap = (reply_len_limit > REPLY_CAP) ? REPLY_CAP : reply_len_limit;
      first_reg = {1'b0, frame_hdr[2], frame_hdr[3]};
      word_count = {1'b0, frame_hdr[4], frame_hdr[5]};
      if (fc == FC_READ_HOLDING) begin
         if (first_reg + word_count > NUM_REGS || int'(word_count) * 2 + 5 > cap) begin
            reply = '{node_addr, fc | EXC_FLAG, EXC_ILLEGAL_ADDRESS};
         end else begin
            reply = '{node_addr, fc, 8'(word_count * 2)};
            for (int i = 0; i < int'(word_count); i++) begin
               reply.push_back(holding_regs[int'(first_reg) + i][15:8]);
               reply.push_back(holding_regs[int'(first_reg) + i][7:0]);
            end
         end
      end else if (fc == FC_WRITE_SINGLE) begin
         if (first_reg >= NUM_REGS) begin
            reply = '{node_addr, fc | EXC_FLAG, EXC_ILLEGAL_ADDRESS};
         end else begin
            holding_regs[int'(first_reg)] = {frame_hdr[4], frame_hdr[5]};
            // echo of the request header, address byte as received
            for (int i = 0; i < 6; i++) reply.push_back(frame_hdr[i]);
         end
      end else begin
         reply = '{node_addr, fc | EXC_FLAG, EXC_ILLEGAL_FUNCTION};
      end
      crc = 16'hFFFF;
      foreach (reply[i]) crc = crc16_byte(crc, reply[i]);
      reply.push_back(crc[7:0]);
      reply.push_back(crc[15:8]);
      served_count = served_count + 16'd1;
      restart_frame();
      foreach (reply[i]) begin
         beat.tx_byte = reply[i];
         beat.reply_last = (i == reply.size() - 1);
         beat.crc_error_total = crc_err_count;
         beat.served_total = served_count;
         pending_replies.push_back(beat);
      end
   endfunction

   // ---------------------------------------------------------------
   // reply side: random back-pressure and comparison
   // ---------------------------------------------------------------
   int rsp_hold;

   always @(posedge clock) begin
      reply_beat_t got;
      reply_beat_t want;
      int          hold_next;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         hold_next = (rsp_hold > 0) ? rsp_hold - 1 : 0;
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (pending_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: reply byte with nothing pending: %h", $realtime, got);
            end else begin
               want = pending_replies.pop_front();
               if (got.tx_byte !== want.tx_byte || got.reply_last !== want.reply_last ||
                   got.crc_error_total !== want.crc_error_total ||
                   got.served_total !== want.served_total) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: reply mismatch byte %h/%h last %b/%b crcerr %h/%h served %h/%h",
                              $realtime, want.tx_byte, got.tx_byte, want.reply_last,
                              got.reply_last, want.crc_error_total, got.crc_error_total,
                              want.served_total, got.served_total);
               end
            end
            // fresh stall for the next transaction
            hold_next = calm ? 0 : $urandom_range(0, 9);
         end
         rsp_hold = hold_next;
         rsp_if.ready <= (hold_next == 0);
      end
   end

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------
   task automatic send_rx_byte(logic [7:0] b, logic last);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= {last, b};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      absorb_rx_byte(b, last);
   endtask

   // frame body followed by its crc; a spoiled crc is flipped in one bit
   task automatic send_frame(logic [7:0] body [$], bit spoil_crc);
      logic [15:0] crc;
      crc = 16'hFFFF;
      foreach (body[i]) crc = crc16_byte(crc, body[i]);
      if (spoil_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      foreach (body[i]) send_rx_byte(body[i], 1'b0);
      send_rx_byte(crc[7:0], 1'b0);
      send_rx_byte(crc[15:8], 1'b1);
   endtask

   // raw bytes, end marked on the last one, no crc added
   task automatic send_raw(logic [7:0] bytes [$]);
      foreach (bytes[i]) send_rx_byte(bytes[i], i == bytes.size() - 1);
   endtask

   // block idle: all replies out, then room for a frame still deciding
   task automatic wait_replies_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [7:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_OWN_ADDRESS) node_addr = value;
      else reply_len_limit = value[6:0];
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      // read of one register, write at the top register, both exceptions
      send_frame('{8'h01, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h01}, 0);
      send_frame('{8'h01, FC_WRITE_SINGLE, 8'h00, 8'h1F, 8'hFF, 8'hFF}, 0);
      send_frame('{8'h01, FC_READ_HOLDING, 8'h00, 8'h1E, 8'h00, 8'h02}, 0);
      send_frame('{8'h01, FC_WRITE_SINGLE, 8'h00, 8'h20, 8'h12, 8'h34}, 0);
      send_frame('{8'h01, FC_READ_HOLDING, 8'h00, 8'h1E, 8'h00, 8'h03}, 0);
      send_frame('{8'h01, 8'h10, 8'h00, 8'h00, 8'h00, 8'h01}, 0);
      send_frame('{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 0);
      // bad crc, runt frames, foreign address, broadcast
      send_frame('{8'h01, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h01}, 1);
      send_raw('{8'hA5});
      send_raw('{8'h01, 8'h03, 8'h00});
      send_frame('{8'h07, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h01}, 0);
      send_frame('{8'h00, FC_WRITE_SINGLE, 8'h00, 8'h00, 8'h80, 8'h01}, 0);
      // four-byte frame: header tail comes from the crc and zeros
      send_frame('{8'h01, FC_READ_HOLDING}, 0);
      send_frame('{8'h01, 8'h2B}, 0);
      // long frame with trailing bytes beyond the header
      send_frame('{8'h01, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h1D, 8'h55, 8'hAA}, 0);
   endtask

   task automatic test_reply_limits();
      wait_replies_drained();
      csr_write(CSR_MAX_REPLY_LEN, 8'd0);
      send_frame('{8'h01, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h00}, 0);
      wait_replies_drained();
      csr_write(CSR_MAX_REPLY_LEN, 8'd7);
      send_frame('{8'h01, FC_READ_HOLDING, 8'h00, 8'h05, 8'h00, 8'h01}, 0);
      send_frame('{8'h01, FC_READ_HOLDING, 8'h00, 8'h05, 8'h00, 8'h02}, 0);
      wait_replies_drained();
      // above the hard cap: 64 bytes still rules
      csr_write(CSR_MAX_REPLY_LEN, 8'hFF);
      send_frame('{8'h01, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h1D}, 0);
      send_frame('{8'h01, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h20}, 0);
      wait_replies_drained();
      csr_write(CSR_MAX_REPLY_LEN, 8'd64);
   endtask

   task automatic test_addresses();
      wait_replies_drained();
      csr_write(CSR_OWN_ADDRESS, 8'hFF);
      send_frame('{8'hFF, FC_READ_HOLDING, 8'h00, 8'h1F, 8'h00, 8'h01}, 0);
      send_frame('{8'h01, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h01}, 0);
      send_frame('{8'h00, 8'h42, 8'h00, 8'h00, 8'h00, 8'h01}, 0);
      wait_replies_drained();
      csr_write(CSR_OWN_ADDRESS, 8'h00);
      send_frame('{8'h00, FC_WRITE_SINGLE, 8'h00, 8'h03, 8'hBE, 8'hEF}, 0);
      wait_replies_drained();
      csr_write(CSR_OWN_ADDRESS, 8'h5A);
   endtask

   // mostly well-formed requests with random content, some noise
   task automatic test_random_traffic(int n_bytes);
      int          sent;
      int          pick;
      logic [7:0]  body [$];
      logic [15:0] first_reg;
      logic [15:0] word_count;
      logic [7:0]  addr;
      logic [7:0]  fc;
      sent = 0;
      while (sent < n_bytes) begin
         pick = $urandom_range(0, 99);
         calm = (pick < 15);
         if (pick < 6) begin
            body = {};
            repeat ($urandom_range(1, 10)) body.push_back(8'($urandom));
            send_raw(body);
            sent += body.size();
            continue;
         end
         pick = $urandom_range(0, 99);
         addr = (pick < 75) ? node_addr : (pick < 85) ? 8'h00 : 8'($urandom);
         pick = $urandom_range(0, 99);
         fc = (pick < 45) ? FC_READ_HOLDING : (pick < 85) ? FC_WRITE_SINGLE : 8'($urandom);
         first_reg = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 33));
         if (fc == FC_WRITE_SINGLE) word_count = 16'($urandom);
         else if ($urandom_range(0, 9) == 0) word_count = 16'($urandom);
         else word_count = 16'($urandom_range(0, 8));
         body = '{addr, fc, first_reg[15:8], first_reg[7:0], word_count[15:8], word_count[7:0]};
         if ($urandom_range(0, 9) == 0) body = body[0:$urandom_range(1, 5)];
         if ($urandom_range(0, 14) == 0)
            repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
         send_frame(body, $urandom_range(0, 9) == 0);
         sent += body.size() + 2;
      end
      calm = 0;
   endtask

   // ---------------------------------------------------------------
   // sequencing
   // ---------------------------------------------------------------
   initial begin
      mismatches = 0;
      calm = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      csr_write_en = 1'b0;
      csr_index = CSR_OWN_ADDRESS;
      csr_write_data = 8'h00;
      node_addr = 8'h01;
      reply_len_limit = 7'd64;
      crc_err_count = 16'h0000;
      served_count = 16'h0000;
      for (int i = 0; i < NUM_REGS; i++) holding_regs[i] = 16'h0000;
      restart_frame();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // leave room for the register clearing pass
      repeat (NUM_REGS + 8) @(posedge clock);

      test_directed();
      test_reply_limits();
      test_addresses();
      test_random_traffic(20);
      // hold off until every reply has come back
      wait_replies_drained();
      csr_write(CSR_MAX_REPLY_LEN, 8'd20);
      test_random_traffic(8);
      wait_replies_drained();
      csr_write(CSR_MAX_REPLY_LEN, 8'd64);
      test_random_traffic(16);

      req_if.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("modbus_rtu_slave_frame_engine_unit test passed");
      end else begin
         $display("modbus_rtu_slave_frame_engine_unit test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("modbus_rtu_slave_frame_engine_unit test failed");
      $finish;
   end

endmodule
